FILE: rtl/shfc_pkg.sv
package shfc_pkg;

    localparam int MHZ_W    = 8;
    localparam int DIV_W    = 16;
    localparam int WIDTH_W  = 16;
    localparam int BITS_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = MHZ_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int SYNC_SHIFT = 7;

    localparam logic [BITS_W-1:0] MAX_BITS = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_MHZ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MHZ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_DIV   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_SPEED = 2'd3;

    localparam logic [MHZ_W-1:0] TIMER_MHZ_RST  = 8'd72;
    localparam logic [MHZ_W-1:0] TARGET_MHZ_RST = 8'd8;

    localparam logic [KIND_W-1:0] KIND_PULSE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd2;

    localparam logic CMD_SEND    = 1'b0;
    localparam logic CMD_CAPTURE = 1'b1;

    typedef enum logic [1:0] {
        JOB_SEND,
        JOB_VERDICT,
        JOB_READ_OK,
        JOB_READ_BAD
    } job_op_t;

    typedef struct packed {
        job_op_t             op;
        logic [BYTE_W-1:0]   payload;
        logic [BITS_W-1:0]   bits;
        logic                flag;
    } job_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] pulse0;
        logic [WIDTH_W-1:0] pulse1;
        logic [WIDTH_W-1:0] period;
        logic [WIDTH_W-1:0] threshold;
    } timing_t;

endpackage

FILE: rtl/shfc_timing.sv
module shfc_timing
    import shfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output timing_t               timing,
    output logic                  timing_ready
);

    typedef enum logic [2:0] {
        T_START,
        T_DIV,
        T_SCALE,
        T_PULSE,
        T_SUM,
        T_READY
    } tstate_t;

    tstate_t            state_reg;
    logic [MHZ_W-1:0]   timer_mhz_reg;
    logic [MHZ_W-1:0]   target_mhz_reg;
    logic [DIV_W-1:0]   meas_div_reg;
    logic               high_speed_reg;
    logic [MHZ_W-1:0]   dvd_reg;
    logic [MHZ_W-1:0]   rem_reg;
    logic [MHZ_W-1:0]   quo_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [WIDTH_W-1:0] p0_reg;
    logic [WIDTH_W-1:0] p1_reg;
    timing_t            timing_reg;

    logic               cfg_wr;
    logic [MHZ_W-1:0]   tdiv;
    logic [MHZ_W:0]     rem_shift;
    logic               rem_ge;
    logic [MHZ_W:0]     q_round;
    logic [DIV_W-1:0]   div_next;
    logic [20:0]        prod0;
    logic [WIDTH_W-1:0] p0_next;
    logic [WIDTH_W-1:0] p1_next;
    logic [WIDTH_W-1:0] sum;

    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign timing       = timing_reg;
    assign timing_ready = (state_reg == T_READY);

    assign tdiv      = (target_mhz_reg == '0) ? MHZ_W'(1) : target_mhz_reg;
    assign rem_shift = {rem_reg, dvd_reg[MHZ_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, tdiv});

    always_comb
    begin
        q_round  = {1'b0, quo_reg} + (MHZ_W+1)'(rem_reg >= (tdiv >> 1));
        div_next = (meas_div_reg != '0) ? meas_div_reg
                                        : DIV_W'({q_round, {SYNC_SHIFT{1'b0}}});
        if (high_speed_reg)
            prod0 = 21'(div_reg) << 3;
        else
            prod0 = (21'(div_reg) << 4) + (21'(div_reg) << 2);
        p0_next = WIDTH_W'(prod0[20:SYNC_SHIFT]) + WIDTH_W'(prod0[SYNC_SHIFT-1]);
        p1_next = WIDTH_W'(div_reg[DIV_W-1:SYNC_SHIFT-1]) + WIDTH_W'(div_reg[SYNC_SHIFT-2]);
        sum     = p0_reg + p1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_START;
            timer_mhz_reg  <= TIMER_MHZ_RST;
            target_mhz_reg <= TARGET_MHZ_RST;
            meas_div_reg   <= '0;
            high_speed_reg <= 1'b0;
            step_reg       <= '0;
        end
        else if (cfg_wr)
        begin
            state_reg <= T_START;
            case (cfg_index)
                REG_TIMER_MHZ:  timer_mhz_reg  <= cfg_data[MHZ_W-1:0];
                REG_TARGET_MHZ: target_mhz_reg <= cfg_data[MHZ_W-1:0];
                REG_MEAS_DIV:   meas_div_reg   <= cfg_data[DIV_W-1:0];
                REG_HIGH_SPEED: high_speed_reg <= cfg_data[0];
                default:        ;
            endcase
        end
        else
        begin
            case (state_reg)
                T_START:
                begin
                    step_reg  <= '0;
                    state_reg <= T_DIV;
                end
                T_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                        state_reg <= T_SCALE;
                end
                T_SCALE: state_reg <= T_PULSE;
                T_PULSE: state_reg <= T_SUM;
                T_SUM:   state_reg <= T_READY;
                T_READY: ;
                default: state_reg <= T_START;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            T_START:
            begin
                dvd_reg <= timer_mhz_reg;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            T_DIV:
            begin
                dvd_reg <= dvd_reg << 1;
                rem_reg <= rem_ge ? MHZ_W'(rem_shift - {1'b0, tdiv}) : rem_shift[MHZ_W-1:0];
                quo_reg <= {quo_reg[MHZ_W-2:0], rem_ge};
            end
            T_SCALE: div_reg <= div_next;
            T_PULSE:
            begin
                p0_reg <= p0_next;
                p1_reg <= p1_next;
            end
            T_SUM:
            begin
                timing_reg.pulse0    <= p0_reg;
                timing_reg.pulse1    <= p1_reg;
                timing_reg.period    <= sum + (sum >> 3);
                timing_reg.threshold <= sum >> 1;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/shfc_front.sv
module shfc_front
    import shfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [BYTE_W-1:0]  frame_value,
    input  logic [BITS_W-1:0]  frame_bits,
    input  logic [WIDTH_W-1:0] captured_width,
    input  logic [WIDTH_W-1:0] threshold,
    input  logic               timing_ready,
    input  logic               q_full,
    output logic               push,
    output job_t               job
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ACK,
        MODE_READ
    } mode_t;

    mode_t              mode_reg,  mode_next;
    logic [BITS_W-1:0]  count_reg, count_next;
    logic [BITS_W-1:0]  ackpos_reg, ackpos_next;
    logic               skip_reg,  skip_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic               sv_reg,    sv_next;

    logic               accept;
    logic [BITS_W-1:0]  bits_c;
    logic [BYTE_W-1:0]  aligned;
    logic               lt;
    logic               le;

    assign in_stall = q_full || !timing_ready;
    assign accept   = in_valid && !in_stall;
    assign bits_c   = (frame_bits > MAX_BITS) ? MAX_BITS : frame_bits;
    assign aligned  = BYTE_W'(frame_value << (MAX_BITS - bits_c));
    assign lt       = (captured_width < threshold);
    assign le       = (captured_width <= threshold);

    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        ackpos_next = ackpos_reg;
        skip_next   = skip_reg;
        shift_next  = shift_reg;
        sv_next     = sv_reg;
        push        = 1'b0;
        job.op      = JOB_SEND;
        job.payload = aligned;
        job.bits    = bits_c;
        job.flag    = ^aligned;
        if (accept)
        begin
            if (command == CMD_SEND)
            begin
                push        = 1'b1;
                mode_next   = MODE_ACK;
                count_next  = '0;
                ackpos_next = bits_c + BITS_W'(2);
                skip_next   = 1'b0;
                shift_next  = '0;
                sv_next     = 1'b0;
            end
            else
            begin
                case (mode_reg)
                    MODE_ACK:
                    begin
                        if (count_reg == ackpos_reg)
                        begin
                            push       = 1'b1;
                            job.op     = JOB_VERDICT;
                            job.flag   = le;
                            mode_next  = MODE_READ;
                            count_next = '0;
                            skip_next  = 1'b0;
                            shift_next = '0;
                            sv_next    = 1'b0;
                        end
                        else
                            count_next = count_reg + 1'b1;
                    end
                    MODE_READ:
                    begin
                        if (skip_reg)
                            skip_next = 1'b0;
                        else if (count_reg == '0)
                        begin
                            sv_next    = lt;
                            shift_next = '0;
                            count_next = BITS_W'(1);
                        end
                        else if (count_reg <= MAX_BITS)
                        begin
                            shift_next = {shift_reg[BYTE_W-2:0], lt};
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            push        = 1'b1;
                            job.payload = shift_reg;
                            if (sv_reg)
                            begin
                                job.op    = JOB_READ_OK;
                                skip_next = 1'b1;
                            end
                            else
                            begin
                                job.op    = JOB_READ_BAD;
                                mode_next = MODE_IDLE;
                            end
                            count_next = '0;
                            shift_next = '0;
                            sv_next    = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            count_reg  <= '0;
            ackpos_reg <= '0;
            skip_reg   <= 1'b0;
            shift_reg  <= '0;
            sv_reg     <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            ackpos_reg <= ackpos_next;
            skip_reg   <= skip_next;
            shift_reg  <= shift_next;
            sv_reg     <= sv_next;
        end
    end

endmodule

FILE: rtl/shfc_queue.sv
module shfc_queue
    import shfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: rtl/shfc_back.sv
module shfc_back
    import shfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  job_t               head,
    output logic               pop,
    input  timing_t            timing,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [KIND_W-1:0]  kind,
    output logic [WIDTH_W-1:0] pulse_width,
    output logic [WIDTH_W-1:0] bit_period,
    output logic [BYTE_W-1:0]  data_byte,
    output logic               ok,
    output logic               last
);

    logic               valid_reg;
    logic [BITS_W-1:0]  idx_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [WIDTH_W-1:0] pw_reg;
    logic [WIDTH_W-1:0] period_reg;
    logic [BYTE_W-1:0]  data_reg;
    logic               ok_reg;
    logic               last_reg;

    logic               load;
    logic               emit;
    logic [KIND_W-1:0]  kind_c;
    logic [WIDTH_W-1:0] pw_c;
    logic [BYTE_W-1:0]  data_c;
    logic               ok_c;
    logic               last_c;
    logic               bit_c;

    assign load = !valid_reg || !out_stall;
    assign emit = load && !q_empty;
    assign pop  = emit && last_c;

    assign out_valid   = valid_reg;
    assign kind        = kind_reg;
    assign pulse_width = pw_reg;
    assign bit_period  = period_reg;
    assign data_byte   = data_reg;
    assign ok          = ok_reg;
    assign last        = last_reg;

    assign bit_c = head.payload[3'(MAX_BITS - idx_reg)];

    always_comb
    begin
        kind_c = KIND_PULSE;
        pw_c   = '0;
        data_c = '0;
        ok_c   = 1'b0;
        last_c = 1'b0;
        case (head.op)
            JOB_SEND:
            begin
                if (idx_reg == '0)
                    pw_c = timing.pulse0;
                else if (idx_reg <= head.bits)
                    pw_c = bit_c ? timing.pulse1 : timing.pulse0;
                else if (idx_reg == head.bits + 1'b1)
                    pw_c = head.flag ? timing.pulse1 : timing.pulse0;
                else
                    last_c = 1'b1;
            end
            JOB_VERDICT:
            begin
                kind_c = KIND_ACK;
                ok_c   = head.flag;
                last_c = 1'b1;
            end
            JOB_READ_OK:
            begin
                if (idx_reg == '0)
                begin
                    kind_c = KIND_BYTE;
                    data_c = head.payload;
                    ok_c   = 1'b1;
                end
                else if (idx_reg == BITS_W'(1))
                    pw_c = timing.pulse1;
                else
                    last_c = 1'b1;
            end
            default:
            begin
                kind_c = KIND_BYTE;
                last_c = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= !q_empty;
            if (emit)
                idx_reg <= last_c ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg   <= kind_c;
            pw_reg     <= pw_c;
            period_reg <= timing.period;
            data_reg   <= data_c;
            ok_reg     <= ok_c;
            last_reg   <= last_c;
        end
    end

endmodule

FILE: rtl/swim_host_frame_codec.sv
// Host side of a single-wire debug link working in pulse widths. A send transaction
// (command 0) yields frame_bits+3 pulse results, frame_bits capped at 8: start, payload
// MSB first, even parity, then a zero-width terminator; capture transactions give at
// most three results (ack verdict, or read byte plus ack pulse and terminator). Results
// leave at one per clock while out_stall is low, set by the back end expanding the queue
// head one result per cycle, and the next transaction is taken while earlier ones drain
// through the two-entry job queue. After reset and after every configuration write
// the input stalls while the timing unit recomputes the pulse widths through its
// 8-step divider.
module swim_host_frame_codec
    import shfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [BYTE_W-1:0]     frame_value,
    input  logic [BITS_W-1:0]     frame_bits,
    input  logic [WIDTH_W-1:0]    captured_width,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KIND_W-1:0]     kind,
    output logic [WIDTH_W-1:0]    pulse_width,
    output logic [WIDTH_W-1:0]    bit_period,
    output logic [BYTE_W-1:0]     data_byte,
    output logic                  ok,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    timing_t timing;
    logic    timing_ready;
    logic    push;
    job_t    push_job;
    logic    pop;
    job_t    head;
    logic    q_empty;
    logic    q_full;

    shfc_timing u_timing (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .timing       (timing),
        .timing_ready (timing_ready)
    );

    shfc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .frame_value    (frame_value),
        .frame_bits     (frame_bits),
        .captured_width (captured_width),
        .threshold      (timing.threshold),
        .timing_ready   (timing_ready),
        .q_full         (q_full),
        .push           (push),
        .job            (push_job)
    );

    shfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    shfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .timing      (timing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .pulse_width (pulse_width),
        .bit_period  (bit_period),
        .data_byte   (data_byte),
        .ok          (ok),
        .last        (last)
    );

endmodule

FILE: rtl/shfc_checker.sv
module shfc_checker
    import shfc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [KIND_W-1:0]     kind,
    input logic [WIDTH_W-1:0]    pulse_width,
    input logic [BYTE_W-1:0]     data_byte,
    input logic                  ok,
    input logic                  last,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    // a stalled result stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // timing recompute blocks new transactions
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> in_stall)
        else $error("input open during timing recompute");

    a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ACK |-> last && pulse_width == '0 && data_byte == '0)
        else $error("bad ack verdict result");

    a_pulse_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_PULSE |-> !ok && data_byte == '0)
        else $error("bad pulse result");

    a_bad_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE && !ok |-> last && data_byte == '0)
        else $error("bad start read not terminal");

endmodule

bind swim_host_frame_codec shfc_checker u_shfc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .pulse_width (pulse_width),
    .data_byte   (data_byte),
    .ok          (ok),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);

FILE: dv/swim_host_frame_codec_tb.sv
module swim_host_frame_codec_tb;
    import shfc_pkg::*;

    localparam int unsigned SYNC_CLOCKS   = 128;
    localparam int unsigned ZERO_CNT_SLOW = 20;
    localparam int unsigned ZERO_CNT_FAST = 8;
    localparam int unsigned ONE_CNT       = 2;
    localparam int unsigned RANDOM_ITEMS  = 60;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef enum logic [1:0] {
        CAP_IDLE,
        CAP_ACK,
        CAP_READ
    } capture_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [WIDTH_W-1:0] pulse_width;
        logic [WIDTH_W-1:0] bit_period;
        logic [BYTE_W-1:0]  data_byte;
        logic               ok;
        logic               last;
    } link_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic [BYTE_W-1:0]     frame_value;
    logic [BITS_W-1:0]     frame_bits;
    logic [WIDTH_W-1:0]    captured_width;
    logic                  out_valid;
    logic                  out_stall;
    logic [KIND_W-1:0]     kind;
    logic [WIDTH_W-1:0]    pulse_width;
    logic [WIDTH_W-1:0]    bit_period;
    logic [BYTE_W-1:0]     data_byte;
    logic                  ok;
    logic                  last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the block's registers and capture state
    logic [MHZ_W-1:0]   cfg_timer_mhz;
    logic [MHZ_W-1:0]   cfg_target_mhz;
    logic [DIV_W-1:0]   cfg_meas_div;
    logic               cfg_high_speed;
    capture_mode_t      cap_mode;
    logic [BITS_W-1:0]  cap_count;
    logic [BITS_W-1:0]  ack_pos;
    logic               skip_echo;
    logic [BYTE_W-1:0]  read_shift;
    logic               start_ok;

    link_result_t pending_results[$];
    link_result_t oldest_pending;

    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned sends_sent;
    int unsigned results_checked;
    int unsigned reg_writes;
    int unsigned burst_left;
    int unsigned cycles_elapsed;

    swim_host_frame_codec u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .frame_value    (frame_value),
        .frame_bits     (frame_bits),
        .captured_width (captured_width),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .pulse_width    (pulse_width),
        .bit_period     (bit_period),
        .data_byte      (data_byte),
        .ok             (ok),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [WIDTH_W-1:0] scale_ticks(input int unsigned cnt,
                                                       input int unsigned div);
        int unsigned prod;
        int unsigned ticks;
        prod = cnt * div;
        ticks = prod / SYNC_CLOCKS;
        if (prod % SYNC_CLOCKS >= SYNC_CLOCKS / 2)
            ticks++;
        return ticks[WIDTH_W-1:0];
    endfunction

    function automatic timing_t link_timing();
        int unsigned div;
        int unsigned tgt;
        int unsigned sum;
        timing_t     tm;
        if (cfg_meas_div != '0)
            div = cfg_meas_div;
        else
        begin
            tgt = (cfg_target_mhz != '0) ? cfg_target_mhz : 1;
            div = cfg_timer_mhz / tgt;
            if (cfg_timer_mhz % tgt >= tgt / 2)
                div++;
            div = (div * SYNC_CLOCKS) & 32'hFFFF;
        end
        tm.pulse0 = scale_ticks(cfg_high_speed ? ZERO_CNT_FAST : ZERO_CNT_SLOW, div);
        tm.pulse1 = scale_ticks(ONE_CNT, div);
        sum = (32'(tm.pulse0) + 32'(tm.pulse1)) & 32'hFFFF;
        tm.period = 16'(sum + (sum >> 3));
        tm.threshold = 16'(sum >> 1);
        return tm;
    endfunction

    function automatic link_result_t make_result(input logic [KIND_W-1:0] k,
                                                 input logic [WIDTH_W-1:0] pw,
                                                 input logic [BYTE_W-1:0] data,
                                                 input logic good,
                                                 input logic [WIDTH_W-1:0] period);
        link_result_t res;
        res.kind = k;
        res.pulse_width = pw;
        res.bit_period = period;
        res.data_byte = data;
        res.ok = good;
        res.last = 1'b0;
        return res;
    endfunction

    task automatic predict_link_results(input logic cmd, input logic [BYTE_W-1:0] value,
                                        input logic [BITS_W-1:0] bits,
                                        input logic [WIDTH_W-1:0] width);
        timing_t      tm;
        link_result_t burst_out[$];
        link_result_t res;
        int           i;
        int unsigned  nbits;
        int unsigned  ones;
        tm = link_timing();
        if (cmd == CMD_SEND)
        begin
            sends_sent++;
            nbits = (bits > MAX_BITS) ? MAX_BITS : bits;
            ones = 0;
            burst_out.push_back(make_result(KIND_PULSE, tm.pulse0, '0, 1'b0, tm.period));
            for (i = nbits; i > 0; i--)
            begin
                if (value[i-1])
                begin
                    burst_out.push_back(make_result(KIND_PULSE, tm.pulse1, '0, 1'b0, tm.period));
                    ones++;
                end
                else
                    burst_out.push_back(make_result(KIND_PULSE, tm.pulse0, '0, 1'b0, tm.period));
            end
            burst_out.push_back(make_result(KIND_PULSE, ones[0] ? tm.pulse1 : tm.pulse0, '0,
                                            1'b0, tm.period));
            burst_out.push_back(make_result(KIND_PULSE, '0, '0, 1'b0, tm.period));
            cap_mode = CAP_ACK;
            cap_count = '0;
            ack_pos = 4'(nbits + 2);
            skip_echo = 1'b0;
            read_shift = '0;
            start_ok = 1'b0;
        end
        else if (cap_mode == CAP_ACK)
        begin
            if (cap_count == ack_pos)
            begin
                burst_out.push_back(make_result(KIND_ACK, '0, '0, width <= tm.threshold,
                                                tm.period));
                cap_mode = CAP_READ;
                cap_count = '0;
                skip_echo = 1'b0;
                read_shift = '0;
                start_ok = 1'b0;
            end
            else
                cap_count = cap_count + 1'b1;
        end
        else if (cap_mode == CAP_READ)
        begin
            if (skip_echo)
                skip_echo = 1'b0;
            else if (cap_count == '0)
            begin
                start_ok = width < tm.threshold;
                read_shift = '0;
                cap_count = 4'd1;
            end
            else if (cap_count <= 4'd8)
            begin
                read_shift = {read_shift[BYTE_W-2:0], width < tm.threshold};
                cap_count = cap_count + 1'b1;
            end
            else
            begin
                if (start_ok)
                begin
                    burst_out.push_back(make_result(KIND_BYTE, '0, read_shift, 1'b1, tm.period));
                    burst_out.push_back(make_result(KIND_PULSE, tm.pulse1, '0, 1'b0, tm.period));
                    burst_out.push_back(make_result(KIND_PULSE, '0, '0, 1'b0, tm.period));
                    skip_echo = 1'b1;
                end
                else
                begin
                    burst_out.push_back(make_result(KIND_BYTE, '0, '0, 1'b0, tm.period));
                    cap_mode = CAP_IDLE;
                end
                cap_count = '0;
                read_shift = '0;
                start_ok = 1'b0;
            end
        end
        else
            return;
        foreach (burst_out[j])
        begin
            res = burst_out[j];
            res.last = (j == burst_out.size() - 1);
            pending_results.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual kind=%0d pulse_width=%0h %s",
                         $time, kind, pulse_width,
                         $sformatf("bit_period=%0h data_byte=%0h ok=%0b last=%0b",
                                   bit_period, data_byte, ok, last));
                fail_count++;
            end
            else
            begin
                oldest_pending = pending_results.pop_front();
                check_field("kind", 32'(oldest_pending.kind), 32'(kind));
                check_field("pulse_width", 32'(oldest_pending.pulse_width), 32'(pulse_width));
                check_field("bit_period", 32'(oldest_pending.bit_period), 32'(bit_period));
                check_field("data_byte", 32'(oldest_pending.data_byte), 32'(data_byte));
                check_field("ok", 32'(oldest_pending.ok), 32'(ok));
                check_field("last", 32'(oldest_pending.last), 32'(last));
                results_checked++;
            end
        end
    end

    // receiver stalls in stretches: none, light, heavy
    initial
    begin
        int unsigned stall_mode;
        int unsigned stretch;
        out_stall <= 1'b0;
        forever
        begin
            stall_mode = $urandom_range(0, 2);
            stretch = $urandom_range(20, 120);
            repeat (stretch)
            begin
                @(posedge clk);
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        cycles_elapsed = 0;
        while (cycles_elapsed < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_elapsed++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("swim_host_frame_codec_tb: FAIL");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] value,
                             input logic [BITS_W-1:0] bits, input logic [WIDTH_W-1:0] width);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        command <= cmd;
        frame_value <= value;
        frame_bits <= bits;
        captured_width <= width;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_link_results(cmd, value, bits, width);
        burst_left--;
        items_sent++;
    endtask

    task automatic capture(input logic [WIDTH_W-1:0] width);
        send_item(CMD_CAPTURE, 8'($urandom), 4'($urandom), width);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TIMER_MHZ:  cfg_timer_mhz = data[MHZ_W-1:0];
            REG_TARGET_MHZ: cfg_target_mhz = data[MHZ_W-1:0];
            REG_MEAS_DIV:   cfg_meas_div = data;
            REG_HIGH_SPEED: cfg_high_speed = data[0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // short pulse decodes as a one and as a valid start bit
    function automatic logic [WIDTH_W-1:0] data_width(input bit short_pulse);
        timing_t     tm;
        int unsigned thr;
        tm = link_timing();
        thr = tm.threshold;
        if (short_pulse && thr > 0)
            return ($urandom_range(0, 1) == 1) ? 16'(thr - 1) : 16'($urandom_range(0, thr - 1));
        return ($urandom_range(0, 1) == 1) ? 16'(thr) : 16'($urandom_range(thr, 65535));
    endfunction

    function automatic logic [WIDTH_W-1:0] ack_width(input bit acked);
        timing_t     tm;
        int unsigned thr;
        tm = link_timing();
        thr = tm.threshold;
        if (acked)
            return ($urandom_range(0, 1) == 1) ? 16'(thr) : 16'($urandom_range(0, thr));
        return ($urandom_range(0, 1) == 1) ? 16'(thr + 1) : 16'($urandom_range(thr + 1, 65535));
    endfunction

    // frame out, wire echo, ack, then read bytes each answered by an ack pulse
    task automatic run_sequence(input int unsigned bits, input int unsigned reads,
                                input bit bad_tail);
        int unsigned echoes;
        int unsigned r;
        int unsigned b;
        echoes = ((bits > MAX_BITS) ? MAX_BITS : bits) + 2;
        send_item(CMD_SEND, 8'($urandom), 4'(bits), 16'($urandom));
        repeat (echoes) capture(16'($urandom));
        capture(ack_width($urandom_range(0, 3) != 0));
        for (r = 0; r < reads; r++)
        begin
            if (r > 0)
                capture(16'($urandom));
            capture(data_width(!(bad_tail && r == reads - 1)));
            for (b = 0; b < 8; b++)
                capture(data_width($urandom_range(0, 1) == 1));
            capture(16'($urandom));
        end
    endtask

    task automatic test_idle_capture();
        capture(16'hFFFF);
        capture(16'h0000);
        wait_drained();
    endtask

    task automatic test_frame_shapes();
        send_item(CMD_SEND, 8'hA5, 4'd8, 16'($urandom));
        send_item(CMD_SEND, 8'hFF, 4'd15, 16'($urandom));
        send_item(CMD_SEND, 8'h00, 4'd0, 16'($urandom));
        send_item(CMD_SEND, 8'h01, 4'd1, 16'($urandom));
        wait_drained();
    endtask

    task automatic test_ack_and_read();
        run_sequence(0, 2, 1'b1);
        wait_drained();
    endtask

    task automatic exercise_setting(input logic [CFG_DATA_W-1:0] timer,
                                    input logic [CFG_DATA_W-1:0] target,
                                    input logic [CFG_DATA_W-1:0] div,
                                    input logic [CFG_DATA_W-1:0] fast);
        write_reg(REG_TIMER_MHZ, timer);
        write_reg(REG_TARGET_MHZ, target);
        write_reg(REG_MEAS_DIV, div);
        write_reg(REG_HIGH_SPEED, fast);
        run_sequence(0, 0, 1'b0);
        send_item(CMD_SEND, 8'($urandom), 4'd8, 16'($urandom));
        wait_drained();
    endtask

    task automatic test_register_settings();
        exercise_setting(16'hAB00 | 16'd255, 16'd1, 16'd0, 16'd0);
        exercise_setting(16'd1, 16'd0, 16'd0, 16'hFFFF);
        exercise_setting(16'd0, 16'd255, 16'd0, 16'd1);
        exercise_setting(16'd72, 16'd8, 16'hFFFF, 16'd1);
        exercise_setting(16'd72, 16'hFF08, 16'hFFFF, 16'd0);
        exercise_setting(16'd72, 16'd8, 16'd1, 16'd1);
        exercise_setting(16'd72, 16'd8, 16'd0, 16'd0);
    endtask

    task automatic test_random_traffic();
        int unsigned first_sent;
        int unsigned bits;
        logic [31:0] noise;
        first_sent = items_sent;
        while (items_sent - first_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    bits = $urandom_range(0, 9);
                    bits = (bits < 4) ? 3 : (bits < 8) ? 8 : $urandom_range(0, 15);
                    run_sequence(bits, $urandom_range(1, 3), $urandom_range(0, 3) == 0);
                end
                6, 7:
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        noise = $urandom;
                        send_item(noise[31], noise[7:0], noise[11:8], 16'($urandom));
                    end
                end
                8:
                begin
                    send_item(CMD_SEND, 8'($urandom), 4'($urandom), 16'($urandom));
                    repeat ($urandom_range(0, 12)) capture(16'($urandom));
                end
                default:
                begin
                    wait_drained();
                    if ($urandom_range(0, 1) == 1)
                    begin
                        repeat ($urandom_range(1, 4))
                            write_reg(2'($urandom), ($urandom_range(0, 3) == 0) ? 16'd0
                                                                               : 16'($urandom));
                    end
                end
            endcase
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        command <= CMD_SEND;
        frame_value <= '0;
        frame_bits <= '0;
        captured_width <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_TIMER_MHZ;
        cfg_data <= '0;
        cfg_timer_mhz = TIMER_MHZ_RST;
        cfg_target_mhz = TARGET_MHZ_RST;
        cfg_meas_div = '0;
        cfg_high_speed = 1'b0;
        cap_mode = CAP_IDLE;
        cap_count = '0;
        ack_pos = '0;
        skip_echo = 1'b0;
        read_shift = '0;
        start_ok = 1'b0;
        fail_count = 0;
        items_sent = 0;
        sends_sent = 0;
        results_checked = 0;
        reg_writes = 0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_capture();
        test_frame_shapes();
        test_ack_and_read();
        test_register_settings();
        test_random_traffic();
        $display("covered %0d input transactions (%0d frame sends), %0d results checked",
                 items_sent, sends_sent, results_checked);
        $display("%0d register writes over reset, extreme and random clock settings", reg_writes);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("swim_host_frame_codec_tb: PASS");
        else
            $display("swim_host_frame_codec_tb: FAIL");
        $finish;
    end

endmodule
